@@ hw/rtl/joystick_velocity_setpoint_integrator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the setpoint integrator checker.
// Every property is clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_VELOCITY_SETPOINT_INTEGRATOR_DEFINES_SVH
`define JOYSTICK_VELOCITY_SETPOINT_INTEGRATOR_DEFINES_SVH

// Same-cycle implication.
`define JVSI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JVSI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/jvsi_pkg.sv @@
// ----------------------------------------------------------------------------
// jvsi_pkg
// Types, constants and tables shared by the setpoint integrator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jvsi_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int ATAN_ENTRIES        = 24;
  localparam int ATAN_IDX_W          = 5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic signed [19:0] PI_Q13     = 20'sd25736;
  localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
  localparam logic [16:0]        ALPHA_ONE  = 17'd65536;

  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_MAX_HSPEED = 3'd0,
    REG_MAX_VSPEED = 3'd1,
    REG_MAX_YAW    = 3'd2,
    REG_DT         = 3'd3,
    REG_ALPHA      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] axis_forward;
    logic signed [15:0] axis_lateral;
    logic signed [15:0] axis_vertical;
    logic signed [15:0] axis_turn;
    logic               speed_assist;
    logic               turn_assist;
    logic signed [15:0] assist_forward;
    logic signed [15:0] assist_lateral;
    logic signed [15:0] assist_vertical;
    logic signed [15:0] assist_turn_rate;
    logic               active;
  } in_t;

  typedef struct packed {
    logic signed [31:0] set_x;
    logic signed [31:0] set_y;
    logic signed [31:0] set_z;
    logic signed [31:0] set_vx;
    logic signed [31:0] set_vy;
    logic signed [31:0] set_vz;
    logic signed [15:0] set_yaw;
    logic [31:0]        sequence_res;
  } out_t;

  // Control for one multiply-accumulate issue.
  typedef struct packed {
    logic issue;
    logic clr;
    logic sh16;
    logic neg;
  } mac_ctl_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [30:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:  r = 31'd843314856;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043836;
      5'd3:  r = 31'd133525158;
      5'd4:  r = 31'd67021686;
      5'd5:  r = 31'd33543515;
      5'd6:  r = 31'd16775850;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194282;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048575;
      5'd11: r = 31'd524287;
      5'd12: r = 31'd262143;
      5'd13: r = 31'd131071;
      5'd14: r = 31'd65535;
      5'd15: r = 31'd32767;
      5'd16: r = 31'd16383;
      5'd17: r = 31'd8191;
      5'd18: r = 31'd4095;
      5'd19: r = 31'd2047;
      5'd20: r = 31'd1023;
      5'd21: r = 31'd511;
      5'd22: r = 31'd255;
      5'd23: r = 31'd127;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/jvsi_mac.sv @@
// ----------------------------------------------------------------------------
// jvsi_mac
// Shared 34x18 signed multiplier with a registered product and a 64-bit
// accumulator. An issue lands in it after its product is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jvsi_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire jvsi_pkg::mac_ctl_t ctl,
  input  wire logic signed [33:0] a,
  input  wire logic signed [17:0] b,
  output logic signed [63:0]      acc
);

  logic signed [51:0] prod_r;
  jvsi_pkg::mac_ctl_t ctl_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] term;
  logic signed [63:0] acc_nxt;

  always_comb begin
    if (ctl_r.sh16) begin
      term = {prod_r[47:0], 16'd0};
    end else begin
      term = {{12{prod_r[51]}}, prod_r};
    end
    if (ctl_r.neg) begin
      term = -term;
    end
    acc_nxt = (ctl_r.clr ? 64'sd0 : acc_r) + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    prod_r <= a * b;
    if (ctl_r.issue) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

@@ hw/rtl/jvsi_cordic.sv @@
// ----------------------------------------------------------------------------
// jvsi_cordic
// Iterative rotation-mode CORDIC: one shift-add step per cycle, giving the
// cosine and sine of a Q3.13 heading in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module jvsi_cordic #(
  parameter int TRIG_ITERATIONS = jvsi_pkg::TRIG_ITERATIONS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] angle,
  output logic                    done,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);

  localparam int IW = jvsi_pkg::ATAN_IDX_W;

  logic               busy_r;
  logic               done_r;
  logic               flip_r;
  logic [IW-1:0]      iter_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic signed [34:0] z_r;
  logic signed [33:0] cos_r;
  logic signed [33:0] sin_r;

  logic signed [34:0] z_init;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [34:0] at;

  always_comb begin
    z_init = {{2{angle[15]}}, angle, 17'd0};
    xs     = x_r >>> iter_r;
    ys     = y_r >>> iter_r;
    at     = {4'd0, jvsi_pkg::atan_q30(iter_r)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
        x_r    <= jvsi_pkg::CORDIC_GAIN;
        y_r    <= '0;
        // Fold angles beyond a quarter turn by pi and negate at the end.
        if (z_init > jvsi_pkg::HALF_PI_Q30) begin
          z_r    <= z_init - jvsi_pkg::PI_Q30;
          flip_r <= 1'b1;
        end else if (z_init < -jvsi_pkg::HALF_PI_Q30) begin
          z_r    <= z_init + jvsi_pkg::PI_Q30;
          flip_r <= 1'b1;
        end else begin
          z_r    <= z_init;
          flip_r <= 1'b0;
        end
      end else if (busy_r) begin
        if (iter_r == IW'(TRIG_ITERATIONS)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          cos_r  <= flip_r ? -x_r : x_r;
          sin_r  <= flip_r ? -y_r : y_r;
        end else begin
          if (!z_r[34]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end
          iter_r <= iter_r + 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

`default_nettype wire

@@ hw/rtl/joystick_velocity_setpoint_integrator.sv @@
// ----------------------------------------------------------------------------
// joystick_velocity_setpoint_integrator
// Turns joystick ticks into position, velocity and heading setpoints.
// ----------------------------------------------------------------------------
// An active tick item passes through the scale, wrap, CORDIC, rotate, axis
// and emit states of a sequencer that runs every multiply through one
// shared 34x18 multiply-accumulate unit and the sine and cosine through
// one iterative CORDIC stage. A load item sets position, clears velocity
// and wraps the heading; an inactive tick is taken in idle and gives no
// result. in_ready is high only between items, but a finished result waits
// in the output register, so the next item may start while it is unread.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_velocity_setpoint_integrator #(
  parameter int TRIG_ITERATIONS = jvsi_pkg::TRIG_ITERATIONS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire jvsi_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output jvsi_pkg::out_t     out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [16:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_WRAP,
    S_CORDIC,
    S_ROT,
    S_AXIS,
    S_EMIT
  } state_t;

  state_t             state_r;
  logic [3:0]         step_r;
  logic [1:0]         k_r;
  logic               load_r;
  jvsi_pkg::in_t      item_r;
  logic [15:0]        mhs_r;
  logic [15:0]        mvs_r;
  logic [15:0]        myr_r;
  logic [15:0]        dt_r;
  logic [16:0]        alpha_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [15:0] hd_r;
  logic [31:0]        cnt_r;
  logic signed [27:0] fwd_r;
  logic signed [27:0] lat_r;
  logic signed [27:0] mz_r;
  logic signed [19:0] rate_r;
  logic signed [19:0] hw_r;
  logic signed [33:0] m0_r;
  logic signed [33:0] m1_r;
  logic               out_valid_r;
  jvsi_pkg::out_t     out_data_r;

  jvsi_pkg::mac_ctl_t mac_ctl;
  logic signed [33:0] mac_a;
  logic signed [17:0] mac_b;
  logic signed [63:0] acc;
  logic               cordic_start;
  logic               cordic_done;
  logic signed [33:0] cos_v;
  logic signed [33:0] sin_v;

  logic signed [63:0] rnd7;
  logic signed [63:0] rnd15;
  logic signed [63:0] rnd16;
  logic signed [63:0] rnd30;
  logic signed [27:0] lin_assist;
  logic signed [27:0] lin_nxt;
  logic signed [19:0] rate_nxt;
  logic signed [19:0] hw_nxt;
  logic signed [31:0] vel_k;
  logic signed [31:0] pos_k;
  logic signed [33:0] m_k;
  logic signed [31:0] vel_nxt;
  logic signed [31:0] pos_nxt;
  logic [16:0]        alpha_eff;
  logic signed [17:0] dt_b;
  logic signed [17:0] fwd_hi;
  logic signed [17:0] fwd_lo;
  logic signed [17:0] lat_hi;
  logic signed [17:0] lat_lo;
  logic               hw_in_range;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  jvsi_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  jvsi_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (hw_r[15:0]),
    .done  (cordic_done),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  always_comb begin
    rnd7  = (acc + 64'sd64) >>> 7;
    rnd15 = (acc + 64'sd16384) >>> 15;
    rnd16 = (acc + 64'sd32768) >>> 16;
    rnd30 = (acc + 64'sd536870912) >>> 30;

    alpha_eff = (alpha_r > jvsi_pkg::ALPHA_ONE) ? jvsi_pkg::ALPHA_ONE : alpha_r;
    dt_b      = {2'b00, dt_r};
    fwd_hi    = {{6{fwd_r[27]}}, fwd_r[27:16]};
    fwd_lo    = {2'b00, fwd_r[15:0]};
    lat_hi    = {{6{lat_r[27]}}, lat_r[27:16]};
    lat_lo    = {2'b00, lat_r[15:0]};

    // Assisted speed for the axis whose product is in the accumulator now.
    lin_assist = '0;
    if (item_r.speed_assist) begin
      case (step_r)
        4'd2:    lin_assist = {{4{item_r.assist_forward[15]}}, item_r.assist_forward, 8'd0};
        4'd3:    lin_assist = {{4{item_r.assist_lateral[15]}}, item_r.assist_lateral, 8'd0};
        default: lin_assist = {{4{item_r.assist_vertical[15]}}, item_r.assist_vertical, 8'd0};
      endcase
    end
    lin_nxt  = rnd7[27:0] + lin_assist;
    rate_nxt = rnd15[19:0] +
               (item_r.turn_assist ?
                {{4{item_r.assist_turn_rate[15]}}, item_r.assist_turn_rate} : 20'sd0);
    hw_nxt   = {{4{hd_r[15]}}, hd_r} + rnd16[19:0];

    vel_k = vel_r[k_r];
    pos_k = pos_r[k_r];
    case (k_r)
      2'd0:    m_k = m0_r;
      2'd1:    m_k = m1_r;
      default: m_k = {{6{mz_r[27]}}, mz_r};
    endcase
    vel_nxt = sat32({{32{vel_k[31]}}, vel_k} + rnd16);
    pos_nxt = sat32({{32{pos_k[31]}}, pos_k} + rnd16);

    hw_in_range  = (hw_r < jvsi_pkg::PI_Q13) && (hw_r >= -jvsi_pkg::PI_Q13);
    cordic_start = (state_r == S_WRAP) && hw_in_range && !load_r;
  end

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (state_r)
      S_SCALE: begin
        case (step_r)
          4'd0: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b0};
            mac_a   = {{18{item_r.axis_forward[15]}}, item_r.axis_forward};
            mac_b   = {2'b00, mhs_r};
          end
          4'd1: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b1};
            mac_a   = {{18{item_r.axis_lateral[15]}}, item_r.axis_lateral};
            mac_b   = {2'b00, mhs_r};
          end
          4'd2: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b0};
            mac_a   = {{18{item_r.axis_vertical[15]}}, item_r.axis_vertical};
            mac_b   = {2'b00, mvs_r};
          end
          4'd3: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b0};
            mac_a   = {{18{item_r.axis_turn[15]}}, item_r.axis_turn};
            mac_b   = {2'b00, myr_r};
          end
          4'd6: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b0};
            mac_a   = {{14{rate_r[19]}}, rate_r};
            mac_b   = dt_b;
          end
          default: ;
        endcase
      end
      S_ROT: begin
        // x' = c*fwd - s*lat, then y' = s*fwd + c*lat, each operand in halves.
        case (step_r)
          4'd0: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b1, neg: 1'b0};
            mac_a   = cos_v;
            mac_b   = fwd_hi;
          end
          4'd1: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh16: 1'b0, neg: 1'b0};
            mac_a   = cos_v;
            mac_b   = fwd_lo;
          end
          4'd2: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh16: 1'b1, neg: 1'b1};
            mac_a   = sin_v;
            mac_b   = lat_hi;
          end
          4'd3: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh16: 1'b0, neg: 1'b1};
            mac_a   = sin_v;
            mac_b   = lat_lo;
          end
          4'd4: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b1, neg: 1'b0};
            mac_a   = sin_v;
            mac_b   = fwd_hi;
          end
          4'd5: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh16: 1'b0, neg: 1'b0};
            mac_a   = sin_v;
            mac_b   = fwd_lo;
          end
          4'd6: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh16: 1'b1, neg: 1'b0};
            mac_a   = cos_v;
            mac_b   = lat_hi;
          end
          4'd7: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b0, sh16: 1'b0, neg: 1'b0};
            mac_a   = cos_v;
            mac_b   = lat_lo;
          end
          default: ;
        endcase
      end
      S_AXIS: begin
        case (step_r)
          4'd0: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b0};
            mac_a   = m_k - {{2{vel_k[31]}}, vel_k};
            mac_b   = {1'b0, alpha_eff};
          end
          4'd3: begin
            mac_ctl = '{issue: 1'b1, clr: 1'b1, sh16: 1'b0, neg: 1'b0};
            mac_a   = {{2{vel_k[31]}}, vel_k};
            mac_b   = dt_b;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      k_r         <= '0;
      load_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mhs_r       <= 16'd256;
      mvs_r       <= 16'd256;
      myr_r       <= 16'd8192;
      dt_r        <= 16'd655;
      alpha_r     <= 17'd6554;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
      hd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (jvsi_pkg::cfg_idx_t'(cfg_index))
          jvsi_pkg::REG_MAX_HSPEED: mhs_r   <= cfg_data[15:0];
          jvsi_pkg::REG_MAX_VSPEED: mvs_r   <= cfg_data[15:0];
          jvsi_pkg::REG_MAX_YAW:    myr_r   <= cfg_data[15:0];
          jvsi_pkg::REG_DT:         dt_r    <= cfg_data[15:0];
          jvsi_pkg::REG_ALPHA:      alpha_r <= cfg_data;
          default: ;
        endcase
      end

      // In S_EMIT the output register is refilled instead of cleared.
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          step_r <= '0;
          if (in_valid) begin
            item_r <= in_data;
            if (in_data.operation == jvsi_pkg::OP_LOAD) begin
              pos_r[0] <= {{8{in_data.axis_forward[15]}}, in_data.axis_forward, 8'd0};
              pos_r[1] <= {{8{in_data.axis_lateral[15]}}, in_data.axis_lateral, 8'd0};
              pos_r[2] <= {{8{in_data.axis_vertical[15]}}, in_data.axis_vertical, 8'd0};
              for (int i = 0; i < 3; i++) begin
                vel_r[i] <= '0;
              end
              hw_r    <= {{4{in_data.axis_turn[15]}}, in_data.axis_turn};
              load_r  <= 1'b1;
              state_r <= S_WRAP;
            end else if (in_data.active) begin
              load_r  <= 1'b0;
              state_r <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd2: fwd_r  <= lin_nxt;
            4'd3: lat_r  <= lin_nxt;
            4'd4: mz_r   <= lin_nxt;
            4'd5: rate_r <= rate_nxt;
            4'd8: begin
              hw_r    <= hw_nxt;
              state_r <= S_WRAP;
            end
            default: ;
          endcase
        end
        S_WRAP: begin
          step_r <= '0;
          if (hw_r >= jvsi_pkg::PI_Q13) begin
            hw_r <= hw_r - jvsi_pkg::TWO_PI_Q13;
          end else if (hw_r < -jvsi_pkg::PI_Q13) begin
            hw_r <= hw_r + jvsi_pkg::TWO_PI_Q13;
          end else begin
            hd_r    <= hw_r[15:0];
            state_r <= load_r ? S_IDLE : S_CORDIC;
          end
        end
        S_CORDIC: begin
          if (cordic_done) begin
            step_r  <= '0;
            state_r <= S_ROT;
          end
        end
        S_ROT: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd5) begin
            m0_r <= rnd30[33:0];
          end
          if (step_r == 4'd9) begin
            m1_r    <= rnd30[33:0];
            step_r  <= '0;
            k_r     <= '0;
            state_r <= S_AXIS;
          end
        end
        S_AXIS: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd2) begin
            vel_r[k_r] <= vel_nxt;
          end
          if (step_r == 4'd5) begin
            pos_r[k_r] <= pos_nxt;
            step_r     <= '0;
            if (k_r == 2'd2) begin
              state_r <= S_EMIT;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        S_EMIT: begin
          // Holds until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r              <= 1'b1;
            out_data_r.set_x         <= pos_r[0];
            out_data_r.set_y         <= pos_r[1];
            out_data_r.set_z         <= pos_r[2];
            out_data_r.set_vx        <= vel_r[0];
            out_data_r.set_vy        <= vel_r[1];
            out_data_r.set_vz        <= vel_r[2];
            out_data_r.set_yaw       <= hd_r;
            out_data_r.sequence_res  <= cnt_r;
            cnt_r                    <= cnt_r + 1'b1;
            state_r                  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/jvsi_checker.sv @@
// ----------------------------------------------------------------------------
// jvsi_checker
// Port-level checks on the setpoint integrator, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joystick_velocity_setpoint_integrator_defines.svh"

module jvsi_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire jvsi_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire jvsi_pkg::out_t out_data
);

  // A result waiting at the output keeps its value.
  `JVSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Any result issued right after one was taken carries the next sequence number.
  `JVSI_ASSERT_NEXT(a_seq_step, out_valid && out_ready, !out_valid || (out_data.sequence_res == $past(out_data.sequence_res) + 32'd1), "sequence number skipped")

  // The heading shown is always wrapped.
  `JVSI_ASSERT_NOW(a_yaw_range, out_valid, (out_data.set_yaw >= -16'sd25736) && (out_data.set_yaw <= 16'sd25735), "heading outside wrap range")

  // Load and active tick items both drop in_ready in the cycle after they are accepted.
  `JVSI_ASSERT_NEXT(a_busy_after, in_valid && in_ready && (in_data.operation || in_data.active), !in_ready, "ready stayed high after a working item")

endmodule

bind joystick_velocity_setpoint_integrator jvsi_checker u_jvsi_checker (.*);

`default_nettype wire

@@ bench/joystick_velocity_setpoint_integrator_test.sv @@
// ----------------------------------------------------------------------------
// Setpoint integrator testbench
// Drives tick and load items through the valid/ready input with random
// gaps, predicts every setpoint from an internal fixed-point model of the
// block, and compares each result field by field as it is accepted.
// ----------------------------------------------------------------------------
module joystick_velocity_setpoint_integrator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TRIG_ITER   = jvsi_pkg::TRIG_ITERATIONS_DEF;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  localparam logic [2:0]  REG_SPARE   = 3'd5;
  localparam int          SETTLE      = 90;
  localparam longint      CYCLE_LIMIT = 2000000;
  localparam longint      GAIN        = 64'sd652032874;
  localparam longint      HALF_PI30   = 64'sd1686629713;
  localparam longint      PI30        = 64'sd3373259426;
  localparam longint      PI13        = 64'sd25736;
  localparam longint      TWO_PI13    = 64'sd51472;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_valid, in_ready, out_valid, out_ready;
  jvsi_pkg::in_t   in_data;
  jvsi_pkg::out_t  out_data;
  logic            cfg_we;
  logic [2:0]      cfg_index;
  logic [16:0]     cfg_data;

  joystick_velocity_setpoint_integrator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [15:0] m_hspeed, m_vspeed, m_yawrate, m_dt;
  logic [16:0] m_alpha;
  longint      m_pos[3], m_vel[3];
  longint      m_heading;
  logic [31:0] m_count;

  jvsi_pkg::out_t setpoints_due[$];
  int     mismatches = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  longint cycles = 0;
  bit     calm = 1'b0;
  int     hold_left = 0;
  int     hold_req = 0;

  longint atan_tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap(longint h);
    longint t;
    t = (h + PI13) % TWO_PI13;
    if (t < 0) t += TWO_PI13;
    return t - PI13;
  endfunction

  function automatic void model_reset();
    m_hspeed = 16'd256; m_vspeed = 16'd256; m_yawrate = 16'd8192;
    m_dt = 16'd655; m_alpha = 17'd6554;
    for (int k = 0; k < 3; k++) begin
      m_pos[k] = 0; m_vel[k] = 0;
    end
    m_heading = 0; m_count = '0;
  endfunction

  // Advances the model by one item; returns 1 when a setpoint comes out.
  function automatic bit predict_setpoint(input jvsi_pkg::in_t it,
                                          output jvsi_pkg::out_t sp);
    longint fwd, lat, rate, z, x, y, nx, c, s, a, dt;
    longint mv[3];
    bit flip;
    sp = '0;
    dt = longint'(m_dt);
    if (it.operation == jvsi_pkg::OP_LOAD) begin
      m_pos[0] = longint'(it.axis_forward) * 256;
      m_pos[1] = longint'(it.axis_lateral) * 256;
      m_pos[2] = longint'(it.axis_vertical) * 256;
      for (int k = 0; k < 3; k++) m_vel[k] = 0;
      m_heading = wrap(longint'(it.axis_turn));
      return 1'b0;
    end
    if (!it.active) return 1'b0;
    fwd = rnd(longint'(m_hspeed) * longint'(it.axis_forward), 7);
    lat = rnd(-(longint'(m_hspeed) * longint'(it.axis_lateral)), 7);
    mv[2] = rnd(longint'(m_vspeed) * longint'(it.axis_vertical), 7);
    if (it.speed_assist) begin
      fwd += longint'(it.assist_forward) * 256;
      lat += longint'(it.assist_lateral) * 256;
      mv[2] += longint'(it.assist_vertical) * 256;
    end
    rate = rnd(longint'(m_yawrate) * longint'(it.axis_turn), 15);
    if (it.turn_assist) rate += longint'(it.assist_turn_rate);
    m_heading = wrap(m_heading + rnd(rate * dt, 16));
    // Rotation angles beyond a quarter turn are folded by half a turn.
    z = m_heading * 131072; x = GAIN; y = 0; flip = 1'b0;
    if (z > HALF_PI30) begin
      z -= PI30; flip = 1'b1;
    end else if (z < -HALF_PI30) begin
      z += PI30; flip = 1'b1;
    end
    for (int i = 0; i < TRIG_ITER && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    mv[0] = rnd(c * fwd - s * lat, 30);
    mv[1] = rnd(s * fwd + c * lat, 30);
    a = (m_alpha > jvsi_pkg::ALPHA_ONE) ? longint'(jvsi_pkg::ALPHA_ONE) : longint'(m_alpha);
    for (int k = 0; k < 3; k++) begin
      m_vel[k] = sat(m_vel[k] + rnd(a * (mv[k] - m_vel[k]), 16));
      m_pos[k] = sat(m_pos[k] + rnd(m_vel[k] * dt, 16));
    end
    sp.set_x = m_pos[0][31:0]; sp.set_y = m_pos[1][31:0]; sp.set_z = m_pos[2][31:0];
    sp.set_vx = m_vel[0][31:0]; sp.set_vy = m_vel[1][31:0]; sp.set_vz = m_vel[2][31:0];
    sp.set_yaw = m_heading[15:0];
    sp.sequence_res = m_count;
    m_count++;
    return 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s of setpoint %0d: expected %h, got %h",
                 name, results_seen, exp_v, got_v);
    end
  endtask

  // Result checker.
  always @(posedge clk) begin
    jvsi_pkg::out_t exp_sp;
    if (rst_n && out_valid && out_ready) begin
      if (setpoints_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected setpoint: %h", out_data);
      end else begin
        exp_sp = setpoints_due.pop_front();
        check_field("set_x", exp_sp.set_x, out_data.set_x);
        check_field("set_y", exp_sp.set_y, out_data.set_y);
        check_field("set_z", exp_sp.set_z, out_data.set_z);
        check_field("set_vx", exp_sp.set_vx, out_data.set_vx);
        check_field("set_vy", exp_sp.set_vy, out_data.set_vy);
        check_field("set_vz", exp_sp.set_vz, out_data.set_vz);
        check_field("set_yaw", 32'(exp_sp.set_yaw), 32'(out_data.set_yaw));
        check_field("sequence_res", exp_sp.sequence_res, out_data.sequence_res);
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left <= hold_req;
      hold_req <= 0;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input jvsi_pkg::in_t it);
    jvsi_pkg::out_t sp;
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (predict_setpoint(it, sp)) setpoints_due.push_back(sp);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (setpoints_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The enable drops again after each write.
  task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      jvsi_pkg::REG_MAX_HSPEED: m_hspeed = val[15:0];
      jvsi_pkg::REG_MAX_VSPEED: m_vspeed = val[15:0];
      jvsi_pkg::REG_MAX_YAW:    m_yawrate = val[15:0];
      jvsi_pkg::REG_DT:         m_dt = val[15:0];
      jvsi_pkg::REG_ALPHA:      m_alpha = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic jvsi_pkg::in_t random_fill();
    logic [191:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return bits[$bits(jvsi_pkg::in_t)-1:0];
  endfunction

  function automatic jvsi_pkg::in_t make_tick(logic signed [15:0] f, l, v, t,
                                              bit sa, bit ta, bit act);
    jvsi_pkg::in_t it;
    it = '0;
    it.operation = jvsi_pkg::OP_TICK;
    it.axis_forward = f; it.axis_lateral = l; it.axis_vertical = v; it.axis_turn = t;
    it.speed_assist = sa; it.turn_assist = ta; it.active = act;
    it.assist_forward = 16'sh7fff; it.assist_lateral = -16'sh8000;
    it.assist_vertical = 16'sh1234; it.assist_turn_rate = -16'sh8000;
    return it;
  endfunction

  function automatic jvsi_pkg::in_t make_load(logic signed [15:0] x, y, z, yaw);
    jvsi_pkg::in_t it;
    it = random_fill();
    it.operation = jvsi_pkg::OP_LOAD;
    it.axis_forward = x; it.axis_lateral = y; it.axis_vertical = z; it.axis_turn = yaw;
    it.active = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic jvsi_pkg::in_t random_item();
    jvsi_pkg::in_t it;
    it = random_fill();
    it.operation = ($urandom_range(99) < 8) ? jvsi_pkg::OP_LOAD : jvsi_pkg::OP_TICK;
    it.active = ($urandom_range(99) < 85);
    // Mostly modest stick values keep the reference away from saturation.
    if ($urandom_range(99) < 70) begin
      it.axis_forward = $signed(16'($urandom_range(8000))) - 16'sd4000;
      it.axis_lateral = $signed(16'($urandom_range(8000))) - 16'sd4000;
      it.axis_vertical = $signed(16'($urandom_range(8000))) - 16'sd4000;
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_tick(16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 1'b1));
    send_item(make_tick(-16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000, 1'b0, 1'b0, 1'b1));
    send_item(make_tick(16'sh4000, 16'sh4000, 16'sd0, 16'sd0, 1'b1, 1'b0, 1'b1));
    send_item(make_tick(16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 1'b0, 1'b1, 1'b1));
    send_item(make_tick(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 1'b0));
    send_item(make_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1));
    send_item(make_load(16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh7fff));
    send_item(make_tick(16'sh2000, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1));
    send_item(make_load(-16'sh8000, 16'sh7fff, -16'sh8000, -16'sh8000));
    send_item(make_tick(16'sd0, 16'sh2000, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1));
    send_item(make_load(16'sd0, 16'sd0, 16'sd0, 16'sd25736));
    send_item(make_tick(16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1));
    send_item(make_load(16'sd0, 16'sd0, 16'sd0, -16'sd25736));
    send_item(make_tick(16'sh7fff, 16'sd0, 16'sd0, -16'sh8000, 1'b1, 1'b1, 1'b1));
    send_item(make_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0));
    send_item(make_tick(-16'sh1000, 16'sh1000, 16'sh1000, 16'sh1000, 1'b0, 1'b0, 1'b1));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    jvsi_pkg::in_t it;
    write_reg(jvsi_pkg::REG_MAX_HSPEED, 17'hffff);
    write_reg(jvsi_pkg::REG_MAX_VSPEED, 17'hffff);
    write_reg(jvsi_pkg::REG_MAX_YAW, 17'hffff);
    write_reg(jvsi_pkg::REG_DT, 17'hffff);
    write_reg(jvsi_pkg::REG_ALPHA, 17'd65536);
    for (int n = 0; n < 6; n++) send_item(make_tick(16'sh7fff, -16'sh8000,
                                                     16'sh7fff, 16'sh7fff,
                                                     1'b1, 1'b1, 1'b1));
    for (int n = 0; n < 6; n++) send_item(make_tick(-16'sh8000, 16'sh7fff,
                                                     -16'sh8000, -16'sh8000,
                                                     1'b1, 1'b1, 1'b1));
    wait_drained();
    // Zero speeds, zero tick period, alpha above one and unused indexes.
    write_reg(jvsi_pkg::REG_MAX_HSPEED, 17'd0);
    write_reg(jvsi_pkg::REG_MAX_VSPEED, 17'd0);
    write_reg(jvsi_pkg::REG_MAX_YAW, 17'd0);
    write_reg(jvsi_pkg::REG_DT, 17'd0);
    write_reg(jvsi_pkg::REG_ALPHA, 17'h1ffff);
    write_reg(REG_UNUSED, 17'h1ffff);
    write_reg(REG_SPARE, 17'h0);
    for (int n = 0; n < 6; n++) begin
      it = random_item();
      send_item(it);
    end
    wait_drained();
    write_reg(jvsi_pkg::REG_ALPHA, 17'd0);
    write_reg(jvsi_pkg::REG_DT, 17'd1);
    for (int n = 0; n < 6; n++) send_item(random_item());
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(jvsi_pkg::REG_MAX_HSPEED, 17'($urandom_range(ph < 2 ? 65535 : 1024)));
      write_reg(jvsi_pkg::REG_MAX_VSPEED, 17'($urandom_range(ph < 2 ? 65535 : 1024)));
      write_reg(jvsi_pkg::REG_MAX_YAW, 17'($urandom));
      write_reg(jvsi_pkg::REG_DT, 17'($urandom_range(65535, 1)));
      write_reg(jvsi_pkg::REG_ALPHA, 17'($urandom_range(70000)));
      calm = (ph == 4);
      for (int n = 0; n < 100; n++) send_item(random_item());
      calm = 1'b0;
      wait_drained();
    end
  endtask

  task automatic test_output_hold();
    write_reg(jvsi_pkg::REG_DT, 17'd655);
    write_reg(jvsi_pkg::REG_ALPHA, 17'd6554);
    @(posedge clk);
    hold_req <= 500;
    for (int n = 0; n < 30; n++) send_item(random_item());
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    model_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_output_hold();
    test_random_phases();
    $display("Sent %0d items and checked %0d setpoints over directed extremes,",
             items_sent, results_seen);
    $display("register extremes, output hold-off and random configuration phases.");
    if (mismatches == 0 && setpoints_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d setpoints missing", mismatches, setpoints_due.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
